FILE: design/swci_pkg.sv
// Shared types, constants and register codes for the sliding-window coincidence index block.
// Used by every module under design/ except swci_ram; depends on nothing else.
package swci_pkg;

	localparam int WINDOW      = 256;
	localparam int ALPHABET    = 26;
	localparam int PAIR_COUNT  = 5;
	localparam int CODE_W      = 5;
	localparam int POS_W       = 8;
	localparam int SLOT_W      = $clog2(WINDOW);
	localparam int FILL_W      = $clog2(WINDOW + 1);
	localparam int CNT_W       = $clog2(WINDOW + 1);
	localparam int SUM_W       = 17;
	localparam int FRAC_W      = 16;
	localparam int Q_W         = 17;
	localparam int TOTAL_W     = 32;
	localparam int WINDOW_SQ   = WINDOW * WINDOW;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int REG_COUNT   = 6;
	localparam int APB_ADDR_W  = $clog2(4 * REG_COUNT);
	localparam int APB_DATA_W  = 32;
	localparam int REG_IDX_W   = APB_ADDR_W - 2;

	localparam logic [7:0] CHAR_UP_A = 8'h41;
	localparam logic [7:0] CHAR_UP_Z = 8'h5A;
	localparam logic [7:0] CHAR_LO_A = 8'h61;
	localparam logic [7:0] CHAR_LO_Z = 8'h7A;

	localparam logic [PAIR_COUNT-1:0][15:0] PAIR_RESET =
		{16'd2580, 16'd2576, 16'd3085, 16'd523, 16'd6};
	localparam logic [PAIR_COUNT-1:0] ENABLE_RESET = '1;

	typedef logic [CODE_W-1:0] code_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PAIR0  = 3'd0,
		REG_PAIR1  = 3'd1,
		REG_PAIR2  = 3'd2,
		REG_PAIR3  = 3'd3,
		REG_PAIR4  = 3'd4,
		REG_ENABLE = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [PAIR_COUNT-1:0][15:0] pairs;
		logic [PAIR_COUNT-1:0]       enable;
	} pair_cfg_t;

	// One classified letter as it travels from the front to the back.
	typedef struct packed {
		code_t              code;
		logic [SLOT_W-1:0]  slot;
		logic               remove;
		logic               emit;
		logic [TOTAL_W-1:0] total;
	} swci_item_t;

endpackage

FILE: design/swci_ram.sv
// Generic RAM: one write port, one or more registered read ports, read-before-write.
// Stand-alone; no package dependency.
module swci_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 5,
	parameter int READS = 2
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [$clog2(DEPTH)-1:0]                 waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [READS-1:0][$clog2(DEPTH)-1:0]      raddr,
	output logic [READS-1:0][WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			for (int i = 0; i < READS; i++) begin
				rdata[i] <= mem[raddr[i]];
			end
		end
	end

endmodule

FILE: design/swci_queue.sv
// Short FIFO of classified items between the front and the back.
// Depends on swci_pkg for the item type and depth.
module swci_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  swci_pkg::swci_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output swci_pkg::swci_item_t head_item
);
	import swci_pkg::*;

	swci_item_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/swci_front.sv
// Front end: accepts text bytes, drops non-letters, folds case, tracks fill and write slot.
// Depends on swci_pkg for constants and the item type.
module swci_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 text_valid,
	input  logic [7:0]           text_byte,
	input  logic                 full,
	output logic                 push,
	output swci_pkg::swci_item_t push_item
);
	import swci_pkg::*;

	logic [SLOT_W-1:0]  slot_q;
	logic [FILL_W-1:0]  fill_q;
	logic [TOTAL_W-1:0] total_q;
	logic               is_upper;
	logic               is_lower;
	logic [7:0]         offset;
	logic               remove;

	always_comb begin
		is_upper = (text_byte >= CHAR_UP_A) && (text_byte <= CHAR_UP_Z);
		is_lower = (text_byte >= CHAR_LO_A) && (text_byte <= CHAR_LO_Z);
		offset   = is_upper ? (text_byte - CHAR_UP_A) : (text_byte - CHAR_LO_A);
		remove   = (fill_q == FILL_W'(WINDOW));
		push     = text_valid && !full && (is_upper || is_lower);

		push_item.code   = offset[CODE_W-1:0];
		push_item.slot   = slot_q;
		push_item.remove = remove;
		// A result appears once this letter completes or slides a full window.
		push_item.emit   = (fill_q >= FILL_W'(WINDOW - 1));
		push_item.total  = (total_q == '1) ? total_q : total_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			fill_q  <= '0;
			total_q <= '0;
		end else if (push) begin
			slot_q  <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
			total_q <= push_item.total;
			if (!remove) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

endmodule

FILE: design/swci_back.sv
// Back end: window stores, letter counts, square sum, pair checks and the result register.
// Depends on swci_pkg and swci_ram.
module swci_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  swci_pkg::swci_item_t   head_item,
	output logic                   pop,
	input  swci_pkg::pair_cfg_t    cfg,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [16:0]            square_sum,
	output logic [16:0]            coincidence_q16,
	output logic                   pattern_match,
	output logic [31:0]            letters_seen
);
	import swci_pkg::*;

	// Window slot of a position counted from the oldest letter after this item's write.
	function automatic logic [SLOT_W-1:0] slot_at(input logic [SLOT_W-1:0] ws,
			input logic [POS_W-1:0] pos);
		logic [POS_W+1:0] sum;
		sum = (POS_W+2)'(ws) + (POS_W+2)'(pos) + 1'b1;
		if (sum >= (POS_W+2)'(WINDOW)) begin
			sum = sum - (POS_W+2)'(WINDOW);
		end
		return sum[SLOT_W-1:0];
	endfunction

	logic                                      adv;
	logic [PAIR_COUNT-1:0][1:0][SLOT_W-1:0]    pair_addr;
	logic [PAIR_COUNT-1:0][1:0][CODE_W-1:0]    pair_data;
	logic [PAIR_COUNT-1:0][1:0]                byp_now;
	logic [PAIR_COUNT-1:0][1:0]                pos_ok;
	code_t                                     old_letter;

	logic                                      vld_s1;
	code_t                                     code_s1;
	logic                                      remove_s1;
	logic                                      emit_s1;
	logic [TOTAL_W-1:0]                        total_s1;
	logic [PAIR_COUNT-1:0][1:0]                byp_s1;

	logic [CNT_W-1:0]                          cnt_q [ALPHABET];
	logic [SUM_W-1:0]                          sum_q;

	logic [CNT_W-1:0]                          cnt_new;
	logic [CNT_W-1:0]                          cnt_old;
	logic [SUM_W+1:0]                          sum_grow;
	logic [SUM_W+1:0]                          sum_shrink;
	logic [SUM_W-1:0]                          sum_next;
	logic [SUM_W+FRAC_W-1:0]                   scaled;
	logic [PAIR_COUNT-1:0]                     pair_ok;
	code_t                                     lt_hi;
	code_t                                     lt_lo;

	logic                                      res_vld_q;
	logic [SUM_W-1:0]                          square_sum_q;
	logic [Q_W-1:0]                            ic_q;
	logic                                      match_q;
	logic [TOTAL_W-1:0]                        seen_q;

	assign adv = !res_vld_q || !result_stall;
	assign pop = head_valid && adv;

	// Each pair gets its own copy of the window so both positions read in the same cycle.
	for (genvar k = 0; k < PAIR_COUNT; k++) begin : g_pair
		for (genvar j = 0; j < 2; j++) begin : g_side
			logic [POS_W-1:0] pos;
			assign pos            = cfg.pairs[k][POS_W*(2-j)-1 -: POS_W];
			assign pair_addr[k][j] = slot_at(head_item.slot, pos);
			assign byp_now[k][j]   = (pos == POS_W'(WINDOW - 1));
			assign pos_ok[k][j]    = ((POS_W+1)'(pos) < (POS_W+1)'(WINDOW));
		end
		swci_ram #(.DEPTH(WINDOW), .WIDTH(CODE_W), .READS(2)) u_pair_ram (
			.clk   (clk),
			.we    (pop),
			.waddr (head_item.slot),
			.wdata (head_item.code),
			.re    (pop),
			.raddr (pair_addr[k]),
			.rdata (pair_data[k])
		);
	end

	swci_ram #(.DEPTH(WINDOW), .WIDTH(CODE_W), .READS(1)) u_old_ram (
		.clk   (clk),
		.we    (pop),
		.waddr (head_item.slot),
		.wdata (head_item.code),
		.re    (pop),
		.raddr (head_item.slot),
		.rdata (old_letter)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			code_s1   <= head_item.code;
			remove_s1 <= head_item.remove;
			emit_s1   <= head_item.emit;
			total_s1  <= head_item.total;
			byp_s1    <= byp_now;
		end
	end

	always_comb begin
		cnt_new = '0;
		cnt_old = '0;
		for (int k = 0; k < ALPHABET; k++) begin
			if (code_s1 == CODE_W'(k)) begin
				cnt_new = cnt_new | cnt_q[k];
			end
			if (old_letter == CODE_W'(k)) begin
				cnt_old = cnt_old | cnt_q[k];
			end
		end

		// Adding a letter with count c raises the sum by 2c+1; removing one lowers it by 2c-1.
		sum_grow   = (SUM_W+2)'(sum_q) + (SUM_W+2)'({cnt_new, 1'b0}) + 1'b1;
		sum_shrink = sum_grow - (SUM_W+2)'({cnt_old, 1'b0}) + 1'b1;
		if (!remove_s1) begin
			sum_next = sum_grow[SUM_W-1:0];
		end else if (old_letter == code_s1) begin
			sum_next = sum_q;
		end else begin
			sum_next = sum_shrink[SUM_W-1:0];
		end
		scaled = {sum_next, FRAC_W'(0)};

		lt_hi = '0;
		lt_lo = '0;
		for (int k = 0; k < PAIR_COUNT; k++) begin
			lt_hi = byp_s1[k][0] ? code_s1 : pair_data[k][0];
			lt_lo = byp_s1[k][1] ? code_s1 : pair_data[k][1];
			pair_ok[k] = !cfg.enable[k] ||
				(pos_ok[k][0] && pos_ok[k][1] && (lt_hi == lt_lo));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			for (int k = 0; k < ALPHABET; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (adv && vld_s1) begin
			sum_q <= sum_next;
			for (int k = 0; k < ALPHABET; k++) begin
				if ((code_s1 == CODE_W'(k)) &&
						!(remove_s1 && (old_letter == CODE_W'(k)))) begin
					cnt_q[k] <= cnt_q[k] + 1'b1;
				end else if ((code_s1 != CODE_W'(k)) && remove_s1 &&
						(old_letter == CODE_W'(k))) begin
					cnt_q[k] <= cnt_q[k] - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= vld_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1 && emit_s1) begin
			square_sum_q <= sum_next;
			ic_q         <= Q_W'(scaled / WINDOW_SQ);
			match_q      <= &pair_ok;
			seen_q       <= total_s1;
		end
	end

	assign result_valid    = res_vld_q;
	assign square_sum      = square_sum_q;
	assign coincidence_q16 = ic_q;
	assign pattern_match   = match_q;
	assign letters_seen    = seen_q;

endmodule

FILE: design/sliding_window_coincidence_index.sv
// Top level of the sliding-window coincidence index: register port, front, queue and back.
// Depends on swci_pkg, swci_front, swci_queue and swci_back.
//
//   channel   direction  handshake                  payload
//   text      in         text_valid / text_stall    text_byte
//   result    out        result_valid / result_stall square_sum, coincidence_q16,
//                                                   pattern_match, letters_seen
//   config    in         APB psel/penable/pwrite    paddr, pwdata, prdata
//
// One text byte is taken per cycle while text_stall is low; a letter's result passes
// through the queue, the window read register and the result register before it leaves.
// Pair copies have one write and two read ports, the old-letter copy one; items can overlap.
// Reset clears counts, fill level, sum and queue; window contents are never read before written.
// A stalled result holds the back end; the four-entry queue keeps the input open until it fills.
module sliding_window_coincidence_index (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            text_valid,
	output logic                            text_stall,
	input  logic [7:0]                      text_byte,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [16:0]                     square_sum,
	output logic [16:0]                     coincidence_q16,
	output logic                            pattern_match,
	output logic [31:0]                     letters_seen,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [swci_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [swci_pkg::APB_DATA_W-1:0] pwdata,
	output logic [swci_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import swci_pkg::*;

	pair_cfg_t  cfg_q;
	reg_idx_t   reg_idx;
	logic       full;
	logic       push;
	swci_item_t push_item;
	logic       pop;
	logic       head_valid;
	swci_item_t head_item;

	assign pready     = 1'b1;
	assign reg_idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign text_stall = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pairs  <= PAIR_RESET;
			cfg_q.enable <= ENABLE_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_PAIR0:  cfg_q.pairs[0] <= pwdata[15:0];
				REG_PAIR1:  cfg_q.pairs[1] <= pwdata[15:0];
				REG_PAIR2:  cfg_q.pairs[2] <= pwdata[15:0];
				REG_PAIR3:  cfg_q.pairs[3] <= pwdata[15:0];
				REG_PAIR4:  cfg_q.pairs[4] <= pwdata[15:0];
				REG_ENABLE: cfg_q.enable   <= pwdata[PAIR_COUNT-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PAIR0:  prdata = APB_DATA_W'(cfg_q.pairs[0]);
			REG_PAIR1:  prdata = APB_DATA_W'(cfg_q.pairs[1]);
			REG_PAIR2:  prdata = APB_DATA_W'(cfg_q.pairs[2]);
			REG_PAIR3:  prdata = APB_DATA_W'(cfg_q.pairs[3]);
			REG_PAIR4:  prdata = APB_DATA_W'(cfg_q.pairs[4]);
			REG_ENABLE: prdata = APB_DATA_W'(cfg_q.enable);
			default:    prdata = '0;
		endcase
	end

	swci_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_byte  (text_byte),
		.full       (full),
		.push       (push),
		.push_item  (push_item)
	);

	swci_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	swci_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head_valid      (head_valid),
		.head_item       (head_item),
		.pop             (pop),
		.cfg             (cfg_q),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.square_sum      (square_sum),
		.coincidence_q16 (coincidence_q16),
		.pattern_match   (pattern_match),
		.letters_seen    (letters_seen)
	);

endmodule

FILE: tb/swci_checker.sv
// Checker for the sliding-window coincidence index: watches the text, result and register ports,
// keeps its own letter window and counts, and compares every result item against its prediction.
// Depends on swci_pkg only.
module swci_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            text_valid,
	input  logic                            text_stall,
	input  logic [7:0]                      text_byte,
	input  logic                            result_valid,
	input  logic                            result_stall,
	input  logic [16:0]                     square_sum,
	input  logic [16:0]                     coincidence_q16,
	input  logic                            pattern_match,
	input  logic [31:0]                     letters_seen,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [swci_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [swci_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [swci_pkg::APB_DATA_W-1:0] prdata,
	output int unsigned                     fail_count,
	output int unsigned                     pending,
	output int unsigned                     results_checked,
	output int unsigned                     pattern_hits
);
	import swci_pkg::*;

	typedef struct packed {
		logic [SUM_W-1:0]   square_sum;
		logic [Q_W-1:0]     coincidence;
		logic               match;
		logic [TOTAL_W-1:0] seen;
	} window_stats_t;

	window_stats_t       expected_stats [$];
	code_t               window_mem [WINDOW];
	logic [CNT_W-1:0]    letter_tally [ALPHABET];
	logic [SLOT_W-1:0]   oldest_slot;
	int unsigned         filled;
	logic [TOTAL_W-1:0]  letter_count;
	logic [15:0]         pair_pos [PAIR_COUNT];
	logic [PAIR_COUNT-1:0] pair_on;
	int unsigned         fails;
	int unsigned         checked;
	int unsigned         hits;

	always @(posedge clk or negedge arst_n) begin : predict
		window_stats_t         want;
		code_t                 code;
		logic                  letter;
		int unsigned           acc;
		logic [63:0]           scaled;
		logic [POS_W-1:0]      hi;
		logic [POS_W-1:0]      lo;
		logic [REG_IDX_W-1:0]  ridx;
		logic [APB_DATA_W-1:0] reg_value;
		if (!arst_n) begin
			for (int k = 0; k < ALPHABET; k++)
				letter_tally[k] = '0;
			for (int k = 0; k < PAIR_COUNT; k++)
				pair_pos[k] = PAIR_RESET[k];
			pair_on = ENABLE_RESET;
			oldest_slot = '0;
			filled = 0;
			letter_count = '0;
			expected_stats.delete();
			fails = 0;
			checked = 0;
			hits = 0;
		end else begin
			// Results are checked before this edge's letter is absorbed; a result never
			// leaves in the cycle its letter is taken.
			if (result_valid && !result_stall) begin
				if (expected_stats.size() == 0) begin
					$error("result item with no letter waiting: square_sum %0d", square_sum);
					fails++;
				end else begin
					want = expected_stats.pop_front();
					if (square_sum !== want.square_sum) begin
						$error("square_sum: expected %0d, got %0d", want.square_sum, square_sum);
						fails++;
					end
					if (coincidence_q16 !== want.coincidence) begin
						$error("coincidence_q16: expected %0d, got %0d",
							want.coincidence, coincidence_q16);
						fails++;
					end
					if (pattern_match !== want.match) begin
						$error("pattern_match: expected %0d, got %0d", want.match, pattern_match);
						fails++;
					end
					if (letters_seen !== want.seen) begin
						$error("letters_seen: expected %0d, got %0d", want.seen, letters_seen);
						fails++;
					end
					checked++;
					if (want.match)
						hits++;
				end
			end

			if (text_valid && !text_stall) begin
				letter = 1'b1;
				code = '0;
				if (text_byte >= CHAR_UP_A && text_byte <= CHAR_UP_Z)
					code = code_t'(text_byte - CHAR_UP_A);
				else if (text_byte >= CHAR_LO_A && text_byte <= CHAR_LO_Z)
					code = code_t'(text_byte - CHAR_LO_A);
				else
					letter = 1'b0;

				if (letter) begin
					if (letter_count != '1)
						letter_count++;
					// A full window drops its oldest letter, which sits in the slot about to be written.
					if (filled >= WINDOW) begin
						if (window_mem[oldest_slot] < ALPHABET
								&& letter_tally[window_mem[oldest_slot]] != '0)
							letter_tally[window_mem[oldest_slot]]--;
					end else begin
						filled++;
					end
					window_mem[oldest_slot] = code;
					letter_tally[code]++;
					oldest_slot = SLOT_W'((int'(oldest_slot) + 1) % WINDOW);

					if (filled >= WINDOW) begin
						acc = 0;
						for (int k = 0; k < ALPHABET; k++)
							acc += int'(letter_tally[k]) * int'(letter_tally[k]);
						want.square_sum = SUM_W'(acc);
						scaled = (64'(want.square_sum) << FRAC_W) / 64'(WINDOW_SQ);
						want.coincidence = Q_W'(scaled);
						want.seen = letter_count;
						// Position 0 is the oldest letter, which is now at the next write slot.
						want.match = 1'b1;
						for (int k = 0; k < PAIR_COUNT; k++) begin
							if (pair_on[k]) begin
								hi = pair_pos[k][15:8];
								lo = pair_pos[k][7:0];
								if (hi >= WINDOW || lo >= WINDOW)
									want.match = 1'b0;
								else if (window_mem[(int'(oldest_slot) + int'(hi)) % WINDOW]
										!= window_mem[(int'(oldest_slot) + int'(lo)) % WINDOW])
									want.match = 1'b0;
							end
						end
						expected_stats.push_back(want);
					end
				end
			end

			if (psel && penable && pready) begin
				ridx = paddr[APB_ADDR_W-1:2];
				if (pwrite) begin
					if (ridx < PAIR_COUNT)
						pair_pos[ridx] = pwdata[15:0];
					else if (ridx == REG_ENABLE)
						pair_on = pwdata[PAIR_COUNT-1:0];
				end else if (ridx < REG_COUNT) begin
					if (ridx == REG_ENABLE)
						reg_value = APB_DATA_W'(pair_on);
					else
						reg_value = APB_DATA_W'(pair_pos[ridx]);
					if (prdata !== reg_value) begin
						$error("prdata: expected %0h, got %0h", reg_value, prdata);
						fails++;
					end
				end
			end
		end
		fail_count      <= fails;
		pending         <= expected_stats.size();
		results_checked <= checked;
		pattern_hits    <= hits;
	end

endmodule

FILE: tb/sliding_window_coincidence_index_tb.sv
// Top of the sliding-window coincidence index testbench: clock, reset, text and register stimulus,
// random result stalls and the final verdict. Depends on swci_pkg, swci_checker and the block.
module sliding_window_coincidence_index_tb;
	import swci_pkg::*;

	localparam int         LETTERS_PER_PHASE = 200;
	localparam int         PHASES            = 7;
	localparam int         HOLD_CYCLES       = 300;
	localparam int         SETTLE_CYCLES     = 12;
	localparam int         CYCLE_LIMIT       = 200000;
	localparam int         IDLE_PERCENT      = 12;
	localparam logic [7:0] CASE_BIT          = 8'h20;
	localparam code_t      LETTER_Q          = 5'd16;

	// Bytes around every letter boundary, with and without the top bit set.
	localparam logic [19:0][7:0] BOUNDARY_BYTES = {
		8'h00, 8'hFF, 8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B,
		8'h7F, 8'h80, 8'hC1, 8'hDA, 8'hE1, 8'hFA, 8'h20, 8'h2E, 8'h4D, 8'h6D
	};

	typedef enum {
		NOISE,
		ANY_LETTER,
		FEW_LETTERS,
		REPEATING,
		SAME_LETTER
	} text_shape_t;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  text_valid   = 1'b0;
	logic                  text_stall;
	logic [7:0]            text_byte    = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [16:0]           square_sum;
	logic [16:0]           coincidence_q16;
	logic                  pattern_match;
	logic [31:0]           letters_seen;
	logic                  psel         = 1'b0;
	logic                  penable      = 1'b0;
	logic                  pwrite       = 1'b0;
	logic [APB_ADDR_W-1:0] paddr        = '0;
	logic [APB_DATA_W-1:0] pwdata       = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned results_checked;
	int unsigned pattern_hits;

	int unsigned items_sent   = 0;
	int unsigned letters_sent = 0;
	int unsigned settings     = 1;
	int unsigned hold_ticket  = 0;
	int unsigned cycle_count  = 0;
	bit          quiet        = 1'b0;

	sliding_window_coincidence_index DUT (.*);

	swci_checker index_check (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result side: random stalls, none while quiet, and one long hold-off per ticket.
	initial begin : result_side
		int unsigned served;
		int unsigned hold_left;
		served = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_ticket != served) begin
				served = hold_ticket;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
			end
		end
	end

	function automatic logic [7:0] spell(input code_t c);
		return ($urandom_range(0, 1) ? CHAR_UP_A : CHAR_LO_A) + 8'(c);
	endfunction

	task automatic send_text(input logic [7:0] b);
		while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
			text_valid <= 1'b0;
			@(posedge clk);
		end
		text_valid <= 1'b1;
		text_byte <= b;
		@(posedge clk);
		while (text_stall)
			@(posedge clk);
		items_sent++;
		if ((b | CASE_BIT) >= CHAR_LO_A && (b | CASE_BIT) <= CHAR_LO_Z)
			letters_sent++;
	endtask

	// One APB transfer followed by a return to idle (psel low), so back-to-back calls never collide.
	task automatic reg_access(input int idx, input logic write, input logic [APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= APB_ADDR_W'(idx * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_all_regs();
		for (int i = 0; i < REG_COUNT; i++)
			reg_access(i, 1'b0, '0);
	endtask

	task automatic program_pairs(input logic [15:0] p0, input logic [15:0] p1,
			input logic [15:0] p2, input logic [15:0] p3, input logic [15:0] p4,
			input logic [PAIR_COUNT-1:0] en);
		// Upper data bits carry junk that the registers must drop.
		reg_access(REG_PAIR0, 1'b1, {16'($urandom), p0});
		reg_access(REG_PAIR1, 1'b1, {16'($urandom), p1});
		reg_access(REG_PAIR2, 1'b1, {16'($urandom), p2});
		reg_access(REG_PAIR3, 1'b1, {16'($urandom), p3});
		reg_access(REG_PAIR4, 1'b1, {16'($urandom), p4});
		reg_access(REG_ENABLE, 1'b1, {27'($urandom), en});
		read_all_regs();
		settings++;
	endtask

	function automatic logic [15:0] near_pair();
		return {8'($urandom_range(0, 24)), 8'($urandom_range(0, 24))};
	endfunction

	task automatic drain();
		text_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic feed_text(input int unsigned goal);
		int unsigned pick;
		int unsigned span;
		int unsigned period;
		text_shape_t shape;
		code_t       motif [12];
		code_t       base;
		logic [7:0]  b;
		while (letters_sent < goal) begin
			pick = $urandom_range(0, 9);
			shape = pick < 2 ? NOISE : pick < 5 ? ANY_LETTER : pick < 7 ? FEW_LETTERS
				: pick < 9 ? REPEATING : SAME_LETTER;
			span = $urandom_range(8, 64);
			period = $urandom_range(1, 12);
			base = code_t'($urandom_range(0, ALPHABET - 3));
			foreach (motif[k])
				motif[k] = code_t'($urandom_range(0, ALPHABET - 1));
			for (int n = 0; n < span && letters_sent < goal; n++) begin
				case (shape)
					NOISE:       b = 8'($urandom);
					ANY_LETTER:  b = spell(code_t'($urandom_range(0, ALPHABET - 1)));
					FEW_LETTERS: b = spell(base + code_t'($urandom_range(0, 2)));
					// A repeating motif lines the pairs up; now and then a stray byte breaks it.
					REPEATING:   b = ($urandom_range(0, 15) == 0) ? 8'($urandom)
						: spell(motif[n % period]);
					default:     b = spell(base);
				endcase
				send_text(b);
			end
		end
	endtask

	initial begin : stimulus
		int unsigned goal;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_all_regs();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph != 0)
				drain();
			goal = letters_sent + LETTERS_PER_PHASE;
			case (ph)
				0: begin
					for (int i = 19; i >= 0; i--)
						send_text(BOUNDARY_BYTES[i]);
				end
				1: begin
					program_pairs(16'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom), 5'($urandom));
					// Writes past the last register must leave everything as it was.
					reg_access(REG_COUNT, 1'b1, $urandom);
					reg_access(REG_COUNT + 1, 1'b1, $urandom);
					read_all_regs();
				end
				2: begin
					program_pairs(16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h8080, '0);
					// A window of one letter in mixed case drives the square sum to its top.
					for (int n = 0; n < 300; n++) begin
						if ($urandom_range(0, 9) == 0)
							send_text(8'h2E);
						send_text(spell(LETTER_Q));
					end
				end
				3: begin
					program_pairs(16'h00FF, 16'hFF00, 16'hFFFF, 16'h0000, 16'h7F80, '1);
					quiet <= 1'b1;
				end
				4: begin
					program_pairs(near_pair(), near_pair(), near_pair(), near_pair(),
						near_pair(), 5'($urandom));
					hold_ticket <= hold_ticket + 1;
				end
				5: begin
					program_pairs(16'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom), 5'($urandom));
				end
				default: begin
					program_pairs(PAIR_RESET[0], PAIR_RESET[1], PAIR_RESET[2],
						PAIR_RESET[3], PAIR_RESET[4], ENABLE_RESET);
				end
			endcase
			feed_text(goal);
			quiet <= 1'b0;
		end
		drain();

		$display("Streamed %0d text items, %0d of them letters, under %0d register settings.",
			items_sent, letters_sent, settings);
		$display("Compared %0d window results; the enabled pairs held in %0d of them.",
			results_checked, pattern_hits);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
design/swci_pkg.sv
design/swci_ram.sv
design/swci_queue.sv
design/swci_front.sv
design/swci_back.sv
design/sliding_window_coincidence_index.sv
tb/swci_checker.sv
tb/sliding_window_coincidence_index_tb.sv
